// ===== rtl/wad_pkg.sv =====
// Package for the window average detector: sizes, register indexes, reset values,
// the controller state type and the command, status and configuration structs.
// Depends on nothing; every other file of the block but wad_ram imports it.
package wad_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int WIN_AW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WIN_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = $clog2(WINDOW_DEPTH * 255 + 1);
    localparam int PROD_W       = 8 + WIN_W;
    localparam int CMP_W        = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DIV_CW       = $clog2(SUM_W + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VAD_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLICES = 3'd4;

    localparam logic [7:0] CUTOFF_RST     = 8'd128;
    localparam logic [6:0] WINDOW_RST     = 7'd5;
    localparam logic       ENABLED_RST    = 1'b1;
    localparam logic       VAD_MODE_RST   = 1'b0;
    localparam logic [7:0] MIN_SLICES_RST = 8'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CHK_RD,
        ST_CHK,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV_START,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic update;
        logic rd_wi;
        logic cool;
        logic scan_init;
        logic scan_rd;
        logic div_start;
        logic div_step;
        logic res_off;
        logic res_zero;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic enabled;
        logic suppress;
        logic scan_last;
        logic div_done;
    } t_sts;

    typedef struct packed {
        logic [7:0]       cutoff;
        logic [WIN_W-1:0] win;
        logic             enabled;
        logic             vad;
        logic [7:0]       min_slices;
    } t_cfg;

endpackage

// ===== rtl/window_average_detector_unit.sv =====
// Top level of the window average detector: configuration registers and the
// controller and datapath instances. Depends on wad_pkg, wad_ctrl and wad_dp.
//
// Usage: one input transaction per feature slice carries a clear command, a
// fresh-probability flag and an 8-bit probability; each one yields exactly one
// output transaction with the detection flag, the window maximum and the floor
// average. Both channels use valid and stall; a transaction moves on a rising
// edge with valid high and stall low. Configuration is a plain write port
// (enable, index, data) the user uses only when idle; the block does not check.
// Rate: one slice at a time. A processed slice steps through update, index read,
// cool-down check, window scan, drain, divider start, division and finish; the
// window scan reads one ring entry per cycle from the ring RAM, and the average
// comes from a restoring divider taking one quotient bit per cycle (14 steps).
// A slice suppressed by cool-down goes from the check straight to finish, and
// one with the block disabled from the update. The result sits in an output
// register, so the next slice is accepted and worked on while the receiver
// stalls; the block then waits in its last step.
// Reset (synchronous, active low) loads the register defaults, clears the ring
// valid bits at once, zeroes the write index and loads the cool-down.
module window_average_detector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_clear_history,
    input  logic                                i_new_valid,
    input  logic [7:0]                          i_probability,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_detected,
    output logic [7:0]                          o_max_probability,
    output logic [7:0]                          o_average_probability,
    input  logic                                i_cfg_we,
    input  logic [wad_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wad_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import wad_pkg::*;

    logic [7:0]       r_cutoff;
    logic [6:0]       r_window;
    logic             r_enabled;
    logic             r_vad;
    logic [7:0]       r_min_slices;
    logic [WIN_W-1:0] eff_win;
    logic             cfg_restart;
    t_cfg             cfg;
    t_cmd             cmd;
    t_sts             sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff     <= CUTOFF_RST;
            r_window     <= WINDOW_RST;
            r_enabled    <= ENABLED_RST;
            r_vad        <= VAD_MODE_RST;
            r_min_slices <= MIN_SLICES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CUTOFF:     r_cutoff     <= i_cfg_data;
                CFG_WINDOW:     r_window     <= i_cfg_data[6:0];
                CFG_ENABLED:    r_enabled    <= i_cfg_data[0];
                CFG_VAD_MODE:   r_vad        <= i_cfg_data[0];
                CFG_MIN_SLICES: r_min_slices <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_window == 7'd0) begin
            eff_win = WIN_W'(1);
        end else if (int'(r_window) > WINDOW_DEPTH) begin
            eff_win = WIN_W'(WINDOW_DEPTH);
        end else begin
            eff_win = WIN_W'(r_window);
        end
    end

    assign cfg_restart = i_cfg_we && (i_cfg_index == CFG_ENABLED) && i_cfg_data[0]
                         && !r_enabled;

    assign cfg.cutoff     = r_cutoff;
    assign cfg.win        = eff_win;
    assign cfg.enabled    = r_enabled;
    assign cfg.vad        = r_vad;
    assign cfg.min_slices = r_min_slices;

    wad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wad_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (cfg),
        .i_cfg_restart         (cfg_restart),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_clear_history       (i_clear_history),
        .i_new_valid           (i_new_valid),
        .i_probability         (i_probability),
        .o_detected            (o_detected),
        .o_max_probability     (o_max_probability),
        .o_average_probability (o_average_probability)
    );

endmodule

// ===== rtl/wad_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no dependencies.
module wad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wad_ctrl.sv =====
// Controller state machine of the window average detector: input and output
// handshakes and the sequence of datapath commands. Depends on wad_pkg.
module wad_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  wad_pkg::t_sts i_sts,
    output wad_pkg::t_cmd o_cmd
);

    import wad_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (!i_sts.enabled) begin
                    o_cmd.res_off = 1'b1;
                    n_state       = ST_FINISH;
                end else begin
                    n_state = ST_CHK_RD;
                end
            end
            ST_CHK_RD: begin
                o_cmd.rd_wi = 1'b1;
                n_state     = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.cool = 1'b1;
                if (i_sts.suppress) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = ST_FINISH;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DIV_START;
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> (!r_out_valid || !i_stall))
        else $error("Result pushed over an untaken transaction.");

    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_UPDATE))
        else $error("Accepted transaction did not start an update.");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |=> o_valid)
        else $error("Pushed result is not offered.");

    a_div_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_sts.div_done) |=> (r_state == ST_FINISH))
        else $error("Division end did not lead to the finish state.");

endmodule

// ===== rtl/wad_dp.sv =====
// Datapath of the window average detector: probability ring with valid bits,
// write index, cool-down counter, window scan, serial divider and result registers.
// Depends on wad_pkg and wad_ram.
module wad_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wad_pkg::t_cfg i_cfg,
    input  logic          i_cfg_restart,
    input  wad_pkg::t_cmd i_cmd,
    output wad_pkg::t_sts o_sts,
    input  logic          i_clear_history,
    input  logic          i_new_valid,
    input  logic [7:0]    i_probability,
    output logic          o_detected,
    output logic [7:0]    o_max_probability,
    output logic [7:0]    o_average_probability
);

    import wad_pkg::*;

    logic                    r_clr;
    logic                    r_fresh;
    logic [7:0]              r_prob;
    logic [WIN_AW-1:0]       r_wi;
    logic [WIN_AW-1:0]       n_wi;
    logic [WINDOW_DEPTH-1:0] r_vld;
    logic [WINDOW_DEPTH-1:0] n_vld;
    logic                    r_rd_vld;
    logic signed [8:0]       r_cool;
    logic signed [8:0]       n_cool;
    logic signed [8:0]       cool_step;
    logic [WIN_AW-1:0]       r_cnt;
    logic                    r_scan_pend;
    logic [SUM_W-1:0]        r_sum;
    logic [7:0]              r_max;
    logic [SUM_W-1:0]        r_quot;
    logic [WIN_W-1:0]        r_rem;
    logic [DIV_CW-1:0]       r_div_cnt;
    logic                    r_det;
    logic                    r_o_det;
    logic [7:0]              r_o_max;
    logic [7:0]              r_o_avg;

    logic                    do_clear;
    logic                    do_write;
    logic [WIN_W-1:0]        wi_inc;
    logic [WIN_AW-1:0]       wi_next;
    logic [WIN_AW-1:0]       rd_addr;
    logic [7:0]              rdata;
    logic [7:0]              rd_val;
    logic [WIN_W:0]          trial;
    logic [WIN_W:0]          trial_sub;
    logic                    trial_ge;
    logic [CMP_W-1:0]        thresh;

    assign do_clear = i_cfg_restart || (i_cmd.update && i_cfg.enabled && r_clr);
    assign do_write = i_cmd.update && i_cfg.enabled && r_fresh;

    assign wi_inc  = WIN_W'(r_wi) + WIN_W'(1);
    assign wi_next = (wi_inc >= i_cfg.win) ? '0 : WIN_AW'(wi_inc);
    assign rd_addr = i_cmd.rd_wi ? r_wi : r_cnt;
    assign rd_val  = r_rd_vld ? rdata : 8'd0;

    wad_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (wi_next),
        .i_wdata (r_prob),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_vld = r_vld;
        if (do_clear) begin
            n_vld = '0;
        end
        if (do_write) begin
            n_vld[wi_next] = 1'b1;
        end
    end

    assign n_wi = do_write ? wi_next : r_wi;

    assign cool_step = ((rd_val < i_cfg.cutoff) && r_cool[8]) ? (r_cool + 9'sd1) : r_cool;

    always_comb begin
        n_cool = r_cool;
        if (do_clear) begin
            n_cool = -$signed({1'b0, i_cfg.min_slices});
        end else if (i_cmd.cool) begin
            n_cool = cool_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi        <= '0;
            r_vld       <= '0;
            r_cool      <= -$signed({1'b0, MIN_SLICES_RST});
            r_scan_pend <= 1'b0;
        end else begin
            r_wi        <= n_wi;
            r_vld       <= n_vld;
            r_cool      <= n_cool;
            r_scan_pend <= i_cmd.scan_rd;
        end
    end

    assign trial     = {r_rem, r_quot[SUM_W-1]};
    assign trial_ge  = (trial >= {1'b0, i_cfg.win});
    assign trial_sub = trial - {1'b0, i_cfg.win};
    assign thresh    = CMP_W'(i_cfg.cutoff) * CMP_W'(i_cfg.win);

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[rd_addr];
        if (i_cmd.load) begin
            r_clr   <= i_clear_history;
            r_fresh <= i_new_valid;
            r_prob  <= i_probability;
        end
        if (i_cmd.scan_init) begin
            r_cnt <= '0;
            r_sum <= '0;
            r_max <= 8'd0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_cnt <= r_cnt + WIN_AW'(1);
            end
            if (r_scan_pend) begin
                r_sum <= r_sum + SUM_W'(rd_val);
                if (rd_val > r_max) begin
                    r_max <= rd_val;
                end
            end
        end
        if (i_cmd.div_start) begin
            r_quot    <= r_sum;
            r_rem     <= '0;
            r_div_cnt <= DIV_CW'(SUM_W);
            r_det     <= (CMP_W'(r_sum) > thresh);
        end else if (i_cmd.div_step) begin
            r_quot    <= {r_quot[SUM_W-2:0], trial_ge};
            r_rem     <= trial_ge ? trial_sub[WIN_W-1:0] : trial[WIN_W-1:0];
            r_div_cnt <= r_div_cnt - DIV_CW'(1);
        end
        if (i_cmd.res_off) begin
            r_det  <= i_cfg.vad;
            r_max  <= 8'd0;
            r_quot <= '0;
        end else if (i_cmd.res_zero) begin
            r_det  <= 1'b0;
            r_max  <= 8'd0;
            r_quot <= '0;
        end
        if (i_cmd.push) begin
            r_o_det <= r_det;
            r_o_max <= r_max;
            r_o_avg <= r_quot[7:0];
        end
    end

    assign o_sts.enabled   = i_cfg.enabled;
    assign o_sts.suppress  = !i_cfg.vad && cool_step[8];
    assign o_sts.scan_last = (WIN_W'(r_cnt) == (i_cfg.win - WIN_W'(1)));
    assign o_sts.div_done  = (r_div_cnt == DIV_CW'(1));

    assign o_detected            = r_o_det;
    assign o_max_probability     = r_o_max;
    assign o_average_probability = r_o_avg;

endmodule

// ===== dv/window_average_detector_unit_tb.sv =====
// Self-checking testbench for window_average_detector_unit: a directed opening, then random
// slices over several register settings and idle patterns, checked against a built-in
// predictor of the detector. Depends on wad_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module window_average_detector_unit_tb;
    import wad_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_REPORTED = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    typedef struct {
        logic       clr;
        logic       fresh;
        logic [7:0] prob;
    } t_slice;

    typedef struct packed {
        logic       detected;
        logic [7:0] max_prob;
        logic [7:0] avg_prob;
    } t_report;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  o_stall;
    logic                  i_clear_history = 1'b0;
    logic                  i_new_valid     = 1'b0;
    logic [7:0]            i_probability   = 8'd0;
    logic                  o_valid;
    logic                  i_stall         = 1'b0;
    logic                  o_detected;
    logic [7:0]            o_max_probability;
    logic [7:0]            o_average_probability;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    window_average_detector_unit u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_clear_history       (i_clear_history),
        .i_new_valid           (i_new_valid),
        .i_probability         (i_probability),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_detected            (o_detected),
        .o_max_probability     (o_max_probability),
        .o_average_probability (o_average_probability),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_slice  slice_queue[$];
    t_report expected_reports[$];
    t_slice  next_slice;
    t_report want_report;
    logic    took        = 1'b0;
    int      send_idle_pct = 0;
    int      stall_pct   = 0;
    int      mismatches  = 0;
    int      quiet_cycles = 0;

    // Predictor state and its copy of the registers.
    logic [7:0]  hist [WINDOW_DEPTH];
    int unsigned wr_pos;
    int          cool;
    logic [7:0]  cut_q;
    logic [6:0]  win_q;
    logic        en_q;
    logic        vad_q;
    logic [7:0]  min_q;

    function automatic int unsigned active_window();
        int unsigned w;
        w = {25'd0, win_q};
        if (w == 0) w = 1;
        if (w > WINDOW_DEPTH) w = WINDOW_DEPTH;
        return w;
    endfunction

    function automatic void wipe_history();
        for (int i = 0; i < WINDOW_DEPTH; i++) hist[i] = 8'd0;
        cool = -int'(min_q);
    endfunction

    function automatic void model_reset();
        cut_q  = CUTOFF_RST;
        win_q  = WINDOW_RST;
        en_q   = ENABLED_RST;
        vad_q  = VAD_MODE_RST;
        min_q  = MIN_SLICES_RST;
        wr_pos = 0;
        wipe_history();
    endfunction

    function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CUTOFF: begin
                cut_q = data;
            end
            CFG_WINDOW: begin
                win_q = data[6:0];
            end
            CFG_ENABLED: begin
                if (data[0] && !en_q) wipe_history();
                en_q = data[0];
            end
            CFG_VAD_MODE: begin
                vad_q = data[0];
            end
            CFG_MIN_SLICES: begin
                min_q = data;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_report predict_slice(logic clr, logic fresh, logic [7:0] prob);
        int unsigned w;
        int unsigned nxt;
        int unsigned sum;
        int unsigned peak;
        t_report     r;
        w = active_window();
        r = '0;
        if (!en_q) begin
            r.detected = vad_q;
            return r;
        end
        if (clr) wipe_history();
        if (fresh) begin
            nxt = wr_pos + 1;
            if (nxt >= w) nxt = 0;
            wr_pos = nxt;
            hist[nxt] = prob;
        end
        if (hist[wr_pos] < cut_q && cool < 0) cool++;
        if (!vad_q && cool < 0) return r;
        sum  = 0;
        peak = 0;
        for (int i = 0; i < w; i++) begin
            sum += {24'd0, hist[i]};
            if ({24'd0, hist[i]} > peak) peak = {24'd0, hist[i]};
        end
        r.detected = (sum > int'(cut_q) * w);
        r.max_prob = peak[7:0];
        r.avg_prob = 8'(sum / w);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_reset();
        end else begin
            if (i_cfg_we) model_write(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) begin
                expected_reports.push_back(
                    predict_slice(i_clear_history, i_new_valid, i_probability));
            end
        end
    end

    always @(posedge i_clk) begin
        took <= i_valid && !o_stall;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || took) begin
            if (slice_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_slice = slice_queue.pop_front();
                i_valid         <= 1'b1;
                i_clear_history <= next_slice.clr;
                i_new_valid     <= next_slice.fresh;
                i_probability   <= next_slice.prob;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED) begin
                    $display("Unexpected transaction: detected=%0d max=%0d avg=%0d",
                             o_detected, o_max_probability, o_average_probability);
                end
            end else begin
                want_report = expected_reports.pop_front();
                if (o_detected !== want_report.detected ||
                    o_max_probability !== want_report.max_prob ||
                    o_average_probability !== want_report.avg_prob) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED) begin
                        $display("Mismatch: expected detected=%0d max=%0d avg=%0d, got %0d %0d %0d",
                                 want_report.detected, want_report.max_prob,
                                 want_report.avg_prob, o_detected, o_max_probability,
                                 o_average_probability);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic set_idle(input t_idle mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 63;
                stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct     = 63;
            end
            default: begin
                send_idle_pct = 28;
                stall_pct     = 28;
            end
        endcase
    endtask

    task automatic push_slice(input logic clr, input logic fresh, input logic [7:0] prob);
        slice_queue.push_back('{clr, fresh, prob});
    endtask

    // Returns once every slice has been accepted and every result has come back,
    // then gives the block time to leave its last step.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (slice_queue.size() != 0 || i_valid || expected_reports.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Speech-like bursts at or above the cutoff alternate with quiet stretches at or below it,
    // with occasional clears, slices without a fresh value and uniform noise.
    task automatic run_phase(input logic [7:0] cut, input logic [6:0] win, input logic en,
                             input logic vad, input logic [7:0] minsl, input int n,
                             input t_idle mode);
        logic       speech;
        logic       clr;
        logic       fresh;
        logic [7:0] p;
        int         r;
        speech = 1'b0;
        wait_idle();
        write_reg(CFG_CUTOFF, cut);
        write_reg(CFG_WINDOW, {1'b0, win});
        write_reg(CFG_VAD_MODE, {7'd0, vad});
        write_reg(CFG_MIN_SLICES, minsl);
        write_reg(CFG_ENABLED, {7'd0, en});
        set_idle(mode);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 10) speech = !speech;
            clr   = ($urandom_range(99) < 3);
            fresh = ($urandom_range(99) < 80);
            r     = $urandom_range(99);
            if (r < 15) p = 8'($urandom_range(255, 0));
            else if (speech) p = 8'($urandom_range(255, cut));
            else p = 8'($urandom_range(cut, 0));
            push_slice(clr, fresh, p);
        end
    endtask

    initial begin
        logic [7:0] rnd_cut;
        logic [6:0] rnd_win;
        logic       rnd_vad;
        logic [7:0] rnd_min;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_idle(IDLE_NONE);

        // Reset settings: long cool-down keeps these suppressed.
        push_slice(1'b0, 1'b1, 8'd200);
        push_slice(1'b0, 1'b0, 8'd0);
        push_slice(1'b1, 1'b1, 8'd255);

        wait_idle();
        write_reg(CFG_MIN_SLICES, 8'd3);
        push_slice(1'b1, 1'b1, 8'd255);
        push_slice(1'b0, 1'b1, 8'd255);
        push_slice(1'b0, 1'b1, 8'd255);
        push_slice(1'b0, 1'b1, 8'd0);
        push_slice(1'b0, 1'b0, 8'd0);
        push_slice(1'b0, 1'b0, 8'd0);
        push_slice(1'b0, 1'b1, 8'd255);
        push_slice(1'b0, 1'b1, 8'd255);
        push_slice(1'b0, 1'b1, 8'd255);
        push_slice(1'b0, 1'b1, 8'd255);
        push_slice(1'b0, 1'b1, 8'd255);
        push_slice(1'b0, 1'b1, 8'd128);
        push_slice(1'b0, 1'b1, 8'd127);
        push_slice(1'b0, 1'b0, 8'hAA);
        push_slice(1'b1, 1'b0, 8'h55);
        push_slice(1'b0, 1'b1, 8'd0);
        push_slice(1'b0, 1'b1, 8'd129);

        run_phase(8'd128, 7'd5,   1'b1, 1'b0, 8'd10,  150, IDLE_NONE);
        run_phase(8'd0,   7'd1,   1'b1, 1'b1, 8'd0,   120, IDLE_SENDER);
        run_phase(8'd255, 7'd64,  1'b1, 1'b0, 8'd255, 150, IDLE_RECEIVER);
        run_phase(8'd100, 7'd3,   1'b1, 1'b0, 8'd5,   100, IDLE_BOTH);
        run_phase(8'd60,  7'd0,   1'b1, 1'b1, 8'd20,  100, IDLE_NONE);
        run_phase(8'd200, 7'd127, 1'b1, 1'b0, 8'd1,   100, IDLE_SENDER);
        run_phase(8'd128, 7'd8,   1'b0, 1'b0, 8'd4,    60, IDLE_RECEIVER);
        run_phase(8'd128, 7'd8,   1'b0, 1'b1, 8'd4,    60, IDLE_BOTH);
        run_phase(8'd90,  7'd16,  1'b1, 1'b0, 8'd6,   150, IDLE_NONE);
        rnd_cut = 8'($urandom_range(255, 0));
        rnd_win = 7'($urandom_range(64, 1));
        rnd_vad = 1'($urandom_range(1, 0));
        rnd_min = 8'($urandom_range(30, 0));
        run_phase(rnd_cut, rnd_win, 1'b1, rnd_vad, rnd_min, 150, IDLE_SENDER);
        rnd_cut = 8'($urandom_range(255, 0));
        rnd_win = 7'($urandom_range(64, 1));
        rnd_vad = 1'($urandom_range(1, 0));
        rnd_min = 8'($urandom_range(30, 0));
        run_phase(rnd_cut, rnd_win, 1'b1, rnd_vad, rnd_min, 100, IDLE_RECEIVER);

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
